[src/bspp_pkg.sv]
// Shared constants, register map and front-to-back command type of the path patcher.
package bspp_pkg;

  localparam int MAX_PATH_DEF = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QAW          = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W       = 4;

  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  localparam logic [1:0] REG_OLD_LENGTH = 2'd0;
  localparam logic [1:0] REG_NEW_LENGTH = 2'd1;
  localparam logic [1:0] REG_TEXT_MODE  = 2'd2;

  localparam logic [7:0] NUL_BYTE = 8'h00;

  typedef struct packed {
    logic       is_load;
    logic [4:0] load_index;
    logic       pre_v;
    logic [7:0] pre_byte;
    logic       pre_match;
    logic       byte_v;
    logic [7:0] body_byte;
    logic       repl_v;
    logic       nul_v;
    logic       pad_v;
    logic       match;
    logic       eoi;
    logic       eof;
  } cmd_t;

endpackage

[src/bspp_ifs.sv]
// Valid/ready channel interfaces for input items and result beats.
interface bspp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic [4:0] load_index;
  logic       stream_end;

  modport source(output valid, output operation, output data_byte, output load_index,
                 output stream_end, input ready);
  modport sink(input valid, input operation, input data_byte, input load_index,
               input stream_end, output ready);
endinterface

interface bspp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_done;
  logic       any_match;

  modport source(output valid, output out_byte, output run_last, output file_done,
                 output any_match, input ready);
  modport sink(input valid, input out_byte, input run_last, input file_done,
               input any_match, output ready);
endinterface

[src/bspp_front.sv]
// Front end: accepts items, keeps the match window and pattern, issues commands.
module bspp_front #(
  parameter int MAX_PATH = bspp_pkg::MAX_PATH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  bspp_item_if.sink                     items,
  input  logic [$clog2(MAX_PATH+1)-1:0] oldl,
  input  logic                          text_mode,
  output bspp_pkg::cmd_t                cmd,
  output logic                          cmd_push,
  input  logic                          cmd_full
);
  import bspp_pkg::*;

  localparam int LW = $clog2(MAX_PATH + 1);
  localparam int IW = $clog2(MAX_PATH);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } front_state_t;

  front_state_t        state, state_next;
  logic [7:0]          win [MAX_PATH];
  logic [7:0]          win_next [MAX_PATH];
  logic [7:0]          pat [MAX_PATH];
  logic [7:0]          shifted [MAX_PATH];
  logic [7:0]          vec [MAX_PATH];
  logic [7:0]          vec_shifted [MAX_PATH];
  logic [MAX_PATH-1:0] lane_eq;
  logic [LW-1:0]       fill, fill_next, wi, newfill;
  logic                in_tail, in_tail_next, matched, matched_next;
  logic                at_len, drain, hit, complete, flush, accept;

  always_comb begin
    for (int i = 0; i < MAX_PATH - 1; i++) begin
      shifted[i]     = win[i + 1];
      vec_shifted[i] = vec[i + 1];
    end
    shifted[MAX_PATH - 1]     = 8'h00;
    vec_shifted[MAX_PATH - 1] = 8'h00;
  end

  assign at_len   = fill == oldl;
  assign drain    = !in_tail && (fill > oldl);
  assign wi       = at_len ? oldl - LW'(1) : fill;
  assign newfill  = wi + LW'(1);
  assign complete = newfill == oldl;

  always_comb begin
    for (int i = 0; i < MAX_PATH; i++) begin
      vec[i]     = (LW'(i) == wi) ? items.data_byte : (at_len ? shifted[i] : win[i]);
      lane_eq[i] = (LW'(i) >= oldl) || (vec[i] == pat[i]);
    end
  end

  assign hit    = &lane_eq;
  assign accept = items.valid && items.ready;

  always_comb begin
    state_next   = state;
    win_next     = win;
    fill_next    = fill;
    in_tail_next = in_tail;
    matched_next = matched;
    items.ready  = 1'b0;
    cmd          = '0;
    cmd_push     = 1'b0;
    flush        = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (items.valid) begin
          unique case (items.operation)
            OP_PATTERN: begin
              items.ready = 1'b1;
            end
            OP_REPLACE: begin
              items.ready    = !cmd_full;
              cmd.is_load    = 1'b1;
              cmd.load_index = items.load_index;
              cmd.body_byte  = items.data_byte;
              cmd_push       = !cmd_full;
            end
            OP_DATA: begin
              if (in_tail) begin
                items.ready   = !cmd_full;
                cmd.byte_v    = 1'b1;
                cmd.body_byte = items.data_byte;
                cmd.match     = matched;
                cmd.nul_v     = items.stream_end && (items.data_byte != NUL_BYTE);
                cmd.pad_v     = items.stream_end || (items.data_byte == NUL_BYTE);
                cmd.eoi       = 1'b1;
                cmd.eof       = items.stream_end;
                cmd_push      = !cmd_full;
                if (!cmd_full) begin
                  in_tail_next = (items.data_byte != NUL_BYTE) && !items.stream_end;
                  if (items.stream_end) begin
                    matched_next = 1'b0;
                    fill_next    = '0;
                  end
                end
              end else if (drain) begin
                cmd.byte_v    = 1'b1;
                cmd.body_byte = win[0];
                cmd.match     = matched;
                cmd_push      = !cmd_full;
                if (!cmd_full) begin
                  win_next  = shifted;
                  fill_next = fill - LW'(1);
                end
              end else begin
                items.ready   = !cmd_full;
                cmd.pre_v     = at_len;
                cmd.pre_byte  = win[0];
                cmd.pre_match = matched;
                if (complete && hit) begin
                  cmd.repl_v   = 1'b1;
                  cmd.match    = 1'b1;
                  cmd.nul_v    = items.stream_end && !text_mode;
                  cmd.pad_v    = items.stream_end && !text_mode;
                  cmd.eoi      = 1'b1;
                  cmd.eof      = items.stream_end;
                  fill_next    = '0;
                  in_tail_next = !text_mode && !items.stream_end;
                  matched_next = !items.stream_end;
                end else begin
                  cmd.match = matched;
                  if (complete) begin
                    cmd.byte_v    = 1'b1;
                    cmd.body_byte = vec[0];
                    win_next      = vec_shifted;
                    fill_next     = oldl - LW'(1);
                    flush         = items.stream_end && (oldl != LW'(1));
                  end else begin
                    win_next  = vec;
                    fill_next = newfill;
                    flush     = items.stream_end;
                  end
                  cmd.eoi = !flush;
                  cmd.eof = items.stream_end && !flush;
                  if (items.stream_end && !flush) begin
                    fill_next    = '0;
                    matched_next = 1'b0;
                    in_tail_next = 1'b0;
                  end
                end
                cmd_push = !cmd_full && (cmd.pre_v || cmd.byte_v || cmd.repl_v ||
                                         cmd.nul_v || cmd.pad_v);
                if (cmd_full) begin
                  win_next     = win;
                  fill_next    = fill;
                  in_tail_next = in_tail;
                  matched_next = matched;
                end else if (flush) begin
                  state_next = ST_FLUSH;
                end
              end
            end
            default: begin
              items.ready = 1'b1;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        cmd.byte_v    = 1'b1;
        cmd.body_byte = win[0];
        cmd.match     = matched;
        cmd.eoi       = fill == LW'(1);
        cmd.eof       = fill == LW'(1);
        cmd_push      = !cmd_full;
        if (!cmd_full) begin
          win_next  = shifted;
          fill_next = fill - LW'(1);
          if (fill == LW'(1)) begin
            state_next   = ST_RUN;
            matched_next = 1'b0;
            in_tail_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      fill    <= '0;
      in_tail <= 1'b0;
      matched <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      in_tail <= in_tail_next;
      matched <= matched_next;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (accept && (items.operation == OP_PATTERN) && (int'(items.load_index) < MAX_PATH)) begin
      pat[IW'(items.load_index)] <= items.data_byte;
    end
  end

endmodule

[src/bspp_queue.sv]
// Short command queue between the front and back ends.
module bspp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bspp_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output bspp_pkg::cmd_t dout,
  output logic           valid
);
  import bspp_pkg::*;

  cmd_t           entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_push, do_pop;

  assign full    = count == (QAW + 1)'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QAW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QAW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

[src/bspp_back.sv]
// Back end: expands commands into output beats, holds the replacement memory.
module bspp_back #(
  parameter int MAX_PATH = bspp_pkg::MAX_PATH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  bspp_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  input  logic [$clog2(MAX_PATH+1)-1:0] oldl,
  input  logic [$clog2(MAX_PATH+1)-1:0] newl,
  bspp_result_if.source                 results
);
  import bspp_pkg::*;

  localparam int CW = $clog2(MAX_PATH + 1);
  localparam int AW = $clog2(MAX_PATH);

  logic [7:0]    repl_mem [MAX_PATH];
  cmd_t          cur, nx, ld_cmd;
  logic          cur_v;
  logic [CW-1:0] repl_idx, nidx, pad_left, npad, padn;
  logic          s2_v, s2_mem, s2_last, s2_done, s2_match;
  logic [7:0]    s2_lit, mem_q;
  logic          s2_free, gen, emit_v, emit_mem, emit_match, rd_en, remain, cur_done;
  logic [7:0]    emit_lit;

  assign padn    = oldl - newl;
  assign s2_free = !s2_v || results.ready;
  assign gen     = cur_v && !cur.is_load && s2_free;

  always_comb begin
    ld_cmd        = q_cmd;
    ld_cmd.repl_v = q_cmd.repl_v && (newl != '0);
    ld_cmd.pad_v  = q_cmd.pad_v && (padn != '0);
  end

  always_comb begin
    nx         = cur;
    nidx       = repl_idx;
    npad       = pad_left;
    emit_v     = 1'b1;
    emit_mem   = 1'b0;
    emit_lit   = NUL_BYTE;
    emit_match = cur.match;
    if (cur.pre_v) begin
      emit_lit   = cur.pre_byte;
      emit_match = cur.pre_match;
      nx.pre_v   = 1'b0;
    end else if (cur.byte_v) begin
      emit_lit  = cur.body_byte;
      nx.byte_v = 1'b0;
    end else if (cur.repl_v) begin
      emit_mem = 1'b1;
      nidx     = repl_idx + CW'(1);
      if (nidx == newl) begin
        nx.repl_v = 1'b0;
      end
    end else if (cur.nul_v) begin
      nx.nul_v = 1'b0;
    end else if (cur.pad_v) begin
      npad = pad_left - CW'(1);
      if (pad_left == CW'(1)) begin
        nx.pad_v = 1'b0;
      end
    end else begin
      emit_v = 1'b0;
    end
  end

  assign remain   = nx.pre_v || nx.byte_v || nx.repl_v || nx.nul_v || nx.pad_v;
  assign rd_en    = gen && emit_mem;
  assign cur_done = cur_v && (cur.is_load || !emit_v || (s2_free && !remain));
  assign q_pop    = q_valid && (!cur_v || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      s2_v  <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_v <= 1'b1;
      end else if (cur_done) begin
        cur_v <= 1'b0;
      end
      if (s2_free) begin
        s2_v <= gen && emit_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= ld_cmd;
      repl_idx <= '0;
      pad_left <= padn;
    end else if (gen && emit_v) begin
      cur      <= nx;
      repl_idx <= nidx;
      pad_left <= npad;
    end
    if (s2_free) begin
      s2_mem   <= emit_mem;
      s2_lit   <= emit_lit;
      s2_match <= emit_match;
      s2_last  <= cur.eoi && !remain;
      s2_done  <= cur.eof && !remain;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_v && cur.is_load && (int'(cur.load_index) < MAX_PATH)) begin
      repl_mem[AW'(cur.load_index)] <= cur.body_byte;
    end
    if (rd_en) begin
      mem_q <= repl_mem[AW'(repl_idx)];
    end
  end

  assign results.valid     = s2_v;
  assign results.out_byte  = s2_mem ? mem_q : s2_lit;
  assign results.run_last  = s2_last;
  assign results.file_done = s2_done;
  assign results.any_match = s2_match;

endmodule

[src/byte_stream_path_patcher.sv]
// Top level of the streaming path patcher: register port, front, queue and back.
//
// Items arrive on the items channel: pattern and replacement bytes are loaded by
// index, then file bytes stream in with stream_end on the last one. Patched bytes
// leave on the results channel; run_last marks the final beat caused by an item
// and file_done the final beat of a file. old_length, new_length and text_mode
// sit on the APB-style port at byte addresses 0, 4 and 8; write them while idle.
// In steady state, with results.ready high and no burst, flush or drain under way,
// one file byte is taken and one beat given every cycle. A match gives a burst of
// min(new_length, old_length) beats from the replacement memory, one per cycle while
// the receiver is ready; a string end gives the null and old_length - new_length zero
// beats. At stream_end the window is flushed oldest first while items are held off, as
// they are while the window drains after old_length is lowered mid-file.
// Reset clears the window, string tail and match flag and sets old_length 1,
// new_length 0, text_mode 0; pattern and replacement contents stay undefined.
// A stalled receiver holds the beat in the output register; the four-entry
// command queue then fills and items.ready drops.
module byte_stream_path_patcher #(
  parameter int MAX_PATH = bspp_pkg::MAX_PATH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  bspp_item_if.sink                     items,
  bspp_result_if.source                 results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bspp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bspp_pkg::*;

  localparam int CW = $clog2(MAX_PATH + 1);

  logic [5:0]    old_length, new_length;
  logic          text_mode;
  logic [CW-1:0] oldl, newl;
  logic          wr_en;
  cmd_t          q_in, q_out;
  logic          q_push, q_full, q_pop, q_valid;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_length <= 6'd1;
      new_length <= 6'd0;
      text_mode  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_OLD_LENGTH: old_length <= pwdata[5:0];
        REG_NEW_LENGTH: new_length <= pwdata[5:0];
        REG_TEXT_MODE:  text_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OLD_LENGTH: prdata = {26'd0, old_length};
      REG_NEW_LENGTH: prdata = {26'd0, new_length};
      REG_TEXT_MODE:  prdata = {31'd0, text_mode};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (old_length == '0) begin
      oldl = CW'(1);
    end else if (int'(old_length) > MAX_PATH) begin
      oldl = CW'(MAX_PATH);
    end else begin
      oldl = CW'(old_length);
    end
    if (int'(new_length) < int'(oldl)) begin
      newl = CW'(new_length);
    end else begin
      newl = oldl;
    end
  end

  bspp_front #(.MAX_PATH(MAX_PATH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .oldl      (oldl),
    .text_mode (text_mode),
    .cmd       (q_in),
    .cmd_push  (q_push),
    .cmd_full  (q_full)
  );

  bspp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .valid (q_valid)
  );

  bspp_back #(.MAX_PATH(MAX_PATH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_out),
    .q_pop   (q_pop),
    .oldl    (oldl),
    .newl    (newl),
    .results (results)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.file_done) |-> results.run_last)
    else $error("file end beat not marked as last of its item");

endmodule

[verif/tb_byte_stream_path_patcher.sv]
// Self-checking testbench for the byte stream path patcher: directed and random files.
`timescale 1ns / 100ps

module tb;
  import bspp_pkg::*;

  localparam logic [1:0] OP_RESERVED    = 2'd3;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         ITEM_TARGET    = 420;
  localparam int         HOLD_CYCLES    = 300;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_done;
    logic       any_match;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bspp_item_if   items_ch();
  bspp_result_if results_ch();

  byte_stream_path_patcher i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // patch predictor state
  logic [7:0]  pattern_mem [32];
  logic [7:0]  replace_mem [32];
  logic [7:0]  window_q    [32];
  int unsigned window_len   = 0;
  logic        tail_open    = 1'b0;
  logic        file_matched = 1'b0;
  logic [5:0]  old_reg      = 6'd1;
  logic [5:0]  new_reg      = 6'd0;
  logic        text_reg     = 1'b0;

  beat_t       expected_beats [$];
  beat_t       step_beats     [$];
  logic [7:0]  file_bytes     [$];

  int unsigned idle_pct        = 0;
  int unsigned stall_pct       = 0;
  int unsigned noise_pct       = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned items_sent      = 0;
  int unsigned data_bytes      = 0;
  int unsigned files_sent      = 0;
  int unsigned beats_checked   = 0;
  int unsigned reg_writes      = 0;
  int unsigned mismatch_count  = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned active_old();
    if (old_reg < 6'd1) return 1;
    if (old_reg > 6'd32) return 32;
    return old_reg;
  endfunction

  function automatic int unsigned active_new();
    return (new_reg < active_old()) ? new_reg : active_old();
  endfunction

  task automatic put_beat(input logic [7:0] b);
    step_beats.push_back('{out_byte: b, run_last: 1'b0, file_done: 1'b0,
                           any_match: file_matched});
  endtask

  task automatic drop_oldest();
    if (window_len == 0) return;
    put_beat(window_q[0]);
    for (int k = 0; k < 31; k++) window_q[k] = window_q[k + 1];
    window_q[31] = 8'h00;
    window_len--;
  endtask

  task automatic put_padding();
    repeat (active_old() - active_new()) put_beat(NUL_BYTE);
  endtask

  task automatic predict_patched_bytes(input logic [1:0] op, input logic [7:0] b,
                                       input logic [4:0] idx, input logic fin);
    int unsigned ol;
    int unsigned nl;
    logic        same;
    beat_t       last_beat;
    if (op == OP_PATTERN) begin
      pattern_mem[idx] = b;
      return;
    end
    if (op == OP_REPLACE) begin
      replace_mem[idx] = b;
      return;
    end
    if (op != OP_DATA) return;
    step_beats.delete();
    ol = active_old();
    nl = active_new();
    if (tail_open) begin
      put_beat(b);
      if (b == NUL_BYTE) begin
        put_padding();
        tail_open = 1'b0;
      end
    end else begin
      while (window_len >= ol) drop_oldest();
      window_q[window_len] = b;
      window_len++;
      if (window_len == ol) begin
        same = 1'b1;
        for (int k = 0; k < ol; k++) if (window_q[k] != pattern_mem[k]) same = 1'b0;
        if (same) begin
          file_matched = 1'b1;
          for (int k = 0; k < nl; k++) put_beat(replace_mem[k]);
          window_len = 0;
          if (!text_reg) tail_open = 1'b1;
        end else begin
          drop_oldest();
        end
      end
    end
    if (fin) begin
      if (tail_open) begin
        put_beat(NUL_BYTE);
        put_padding();
      end
      while (window_len > 0) drop_oldest();
    end
    if (step_beats.size() > 0) begin
      last_beat = step_beats[step_beats.size() - 1];
      last_beat.run_last = 1'b1;
      if (fin) last_beat.file_done = 1'b1;
      step_beats[step_beats.size() - 1] = last_beat;
    end
    if (fin) begin
      window_len   = 0;
      tail_open    = 1'b0;
      file_matched = 1'b0;
      for (int k = 0; k < 32; k++) window_q[k] = 8'h00;
    end
    foreach (step_beats[k]) expected_beats.push_back(step_beats[k]);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                           input logic [4:0] idx, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      items_ch.valid = 1'b0;
    end
    @(negedge clk);
    items_ch.valid      = 1'b1;
    items_ch.operation  = op;
    items_ch.data_byte  = b;
    items_ch.load_index = idx;
    items_ch.stream_end = fin;
    do @(posedge clk); while (!items_ch.ready);
    predict_patched_bytes(op, b, idx, fin);
    items_sent++;
    if (op == OP_DATA) begin
      data_bytes++;
      if (fin) files_sent++;
    end
  endtask

  // drop valid, wait for every beat, then let the block finish any flush
  task automatic settle_block();
    @(negedge clk);
    items_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [5:0] value);
    logic [31:0] want;
    want = (sel == REG_TEXT_MODE) ? {31'b0, value[0]} : {26'b0, value};
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = want;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_OLD_LENGTH: old_reg  = value;
      REG_NEW_LENGTH: new_reg  = value;
      REG_TEXT_MODE:  text_reg = value[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d readback expected %h got %h", $time, sel, want, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_store(input logic [1:0] op, input string s);
    for (int k = 0; k < s.len(); k++) send_item(op, s[k], k[4:0], 1'($urandom_range(1)));
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) file_bytes.push_back(s[k]);
  endtask

  task automatic send_file_bytes(input logic close);
    for (int k = 0; k < file_bytes.size(); k++) begin
      if ($urandom_range(99) < noise_pct)
        send_item(OP_RESERVED, 8'($urandom_range(255)), 5'($urandom_range(31)),
                  1'($urandom_range(1)));
      send_item(OP_DATA, file_bytes[k], 5'($urandom_range(31)),
                close && (k == file_bytes.size() - 1));
    end
    file_bytes.delete();
  endtask

  function automatic logic [7:0] random_symbol();
    if ($urandom_range(7) == 0) return NUL_BYTE;
    if ($urandom_range(15) == 0) return 8'hFF;
    return 8'h41 + 8'($urandom_range(3));
  endfunction

  task automatic set_idle(input idle_mix_e mix);
    case (mix)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 48; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 48; end
      IDLE_BOTH:     begin idle_pct = 35; stall_pct = 35; end
      default: ;
    endcase
  endtask

  task automatic test_store_loads();
    for (int k = 0; k < 32; k++)
      send_item(OP_PATTERN, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom_range(255)),
                k[4:0], 1'($urandom_range(1)));
    for (int k = 0; k < 32; k++)
      send_item(OP_REPLACE, (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom_range(255)),
                k[4:0], 1'($urandom_range(1)));
    send_item(OP_RESERVED, 8'hFF, 5'd31, 1'b1);
    settle_block();
  endtask

  task automatic test_binary_patch();
    write_reg(REG_OLD_LENGTH, 6'd4);
    write_reg(REG_NEW_LENGTH, 6'd2);
    write_reg(REG_TEXT_MODE, 6'd0);
    load_store(OP_PATTERN, "/usr");
    load_store(OP_REPLACE, "/o");
    push_text("a/usrb");
    file_bytes.push_back(NUL_BYTE);
    file_bytes.push_back(8'hFF);
    push_text("/usr");
    send_file_bytes(1'b1);
    settle_block();
  endtask

  task automatic test_text_replace();
    write_reg(REG_TEXT_MODE, 6'd1);
    write_reg(REG_NEW_LENGTH, 6'd32);
    load_store(OP_REPLACE, "/opt");
    push_text("/usr/usrx/u");
    send_file_bytes(1'b1);
    settle_block();
    // empty replacement completing on the last byte gives no beat at all
    write_reg(REG_NEW_LENGTH, 6'd0);
    push_text("/usr");
    send_file_bytes(1'b1);
    settle_block();
  endtask

  task automatic test_null_in_pattern();
    write_reg(REG_OLD_LENGTH, 6'd3);
    write_reg(REG_NEW_LENGTH, 6'd1);
    write_reg(REG_TEXT_MODE, 6'd0);
    load_store(OP_PATTERN, "a?b");
    send_item(OP_PATTERN, NUL_BYTE, 5'd1, 1'b0);
    load_store(OP_REPLACE, "Z");
    file_bytes.push_back(8'h61);
    file_bytes.push_back(NUL_BYTE);
    push_text("bcd");
    file_bytes.push_back(NUL_BYTE);
    send_file_bytes(1'b1);
    settle_block();
  endtask

  task automatic test_mid_file_registers();
    write_reg(REG_OLD_LENGTH, 6'd6);
    write_reg(REG_NEW_LENGTH, 6'd2);
    load_store(OP_PATTERN, "abcdef");
    push_text("xy");
    send_file_bytes(1'b0);
    settle_block();
    write_reg(REG_OLD_LENGTH, 6'd1);
    push_text("aq");
    send_file_bytes(1'b0);
    settle_block();
    write_reg(REG_TEXT_MODE, 6'd1);
    push_text("r");
    file_bytes.push_back(NUL_BYTE);
    push_text("as");
    send_file_bytes(1'b1);
    settle_block();
  endtask

  task automatic test_backpressure();
    write_reg(REG_OLD_LENGTH, 6'd3);
    write_reg(REG_NEW_LENGTH, 6'd3);
    write_reg(REG_TEXT_MODE, 6'd1);
    load_store(OP_PATTERN, "abc");
    load_store(OP_REPLACE, "XYZ");
    hold_off_cycles = HOLD_CYCLES;
    repeat (40) file_bytes.push_back(8'h61 + 8'($urandom_range(2)));
    send_file_bytes(1'b1);
    settle_block();
  endtask

  task automatic test_random_files();
    int unsigned phase;
    int unsigned ol;
    int unsigned nl;
    int unsigned pick;
    int unsigned target;
    phase      = 0;
    noise_pct  = 3;
    while ((items_sent < ITEM_TARGET) || (phase < 4)) begin
      case (phase % 6)
        0: begin ol = 1;  nl = 0;  end
        1: begin ol = 32; nl = 32; end
        2: begin ol = 1;  nl = 32; end
        3: begin ol = 32; nl = 0;  end
        default: begin
          ol = $urandom_range(8, 2);
          nl = $urandom_range(ol + 2, 0);
        end
      endcase
      settle_block();
      set_idle(idle_mix_e'(phase % 4));
      write_reg(REG_OLD_LENGTH, ol[5:0]);
      write_reg(REG_NEW_LENGTH, nl[5:0]);
      write_reg(REG_TEXT_MODE, 6'($urandom_range(1)));
      for (int k = 0; k < ol; k++)
        send_item(OP_PATTERN, random_symbol(), k[4:0], 1'($urandom_range(1)));
      for (int k = 0; k < nl && k < 32; k++)
        send_item(OP_REPLACE, 8'($urandom_range(255)), k[4:0], 1'($urandom_range(1)));
      repeat (2) begin
        target = $urandom_range((ol == 32) ? 70 : 3 * ol + 10, 1);
        while (file_bytes.size() < target) begin
          pick = $urandom_range(99);
          if (pick < 35) for (int k = 0; k < active_old(); k++)
            file_bytes.push_back(pattern_mem[k]);
          else if (pick < 45) file_bytes.push_back(NUL_BYTE);
          else if (pick < 80) file_bytes.push_back(random_symbol());
          else file_bytes.push_back(8'($urandom_range(255)));
        end
        send_file_bytes(1'b1);
      end
      phase++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      results_ch.ready = 1'b0;
      hold_off_cycles--;
    end else begin
      results_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (results_ch.valid && results_ch.ready) begin
      got = '{out_byte: results_ch.out_byte, run_last: results_ch.run_last,
              file_done: results_ch.file_done, any_match: results_ch.any_match};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got byte %h last %b done %b match %b",
                 $time, got.out_byte, got.run_last, got.file_done, got.any_match);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (got !== want) begin
          $display("%0t: beat mismatch, expected byte %h last %b done %b match %b",
                   $time, want.out_byte, want.run_last, want.file_done, want.any_match);
          $display("%0t:                got      byte %h last %b done %b match %b",
                   $time, got.out_byte, got.run_last, got.file_done, got.any_match);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d beats outstanding",
               $time, quiet_cycles, expected_beats.size());
      $display("byte_stream_path_patcher verification failed");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    items_ch.valid      = 1'b0;
    items_ch.operation  = OP_DATA;
    items_ch.data_byte  = 8'h00;
    items_ch.load_index = 5'd0;
    items_ch.stream_end = 1'b0;
    results_ch.ready    = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = 32'h0;
    for (int k = 0; k < 32; k++) window_q[k] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_idle(IDLE_NONE);
    test_store_loads();
    test_binary_patch();
    test_text_replace();
    test_null_in_pattern();
    test_mid_file_registers();
    test_backpressure();
    test_random_files();
    settle_block();

    $display("covered %0d items, %0d file bytes in %0d files, %0d beats checked",
             items_sent, data_bytes, files_sent, beats_checked);
    $display("%0d register writes over binary and text modes, pattern lengths 1 to 32",
             reg_writes);
    if (mismatch_count == 0)
      $display("byte_stream_path_patcher verification clean");
    else
      $display("byte_stream_path_patcher verification failed");
    $finish;
  end

endmodule

[byte_stream_path_patcher.f]
src/bspp_pkg.sv
src/bspp_ifs.sv
src/bspp_front.sv
src/bspp_queue.sv
src/bspp_back.sv
src/byte_stream_path_patcher.sv
verif/tb_byte_stream_path_patcher.sv
